FILE: design/region_map_access_checker_core_defines.svh
// Assertion helpers for the checker file.
`ifndef REGION_MAP_ACCESS_CHECKER_CORE_DEFINES_SVH
`define REGION_MAP_ACCESS_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RMAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmac check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define RMAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmac check failed");

`endif

FILE: design/rmac_pkg.sv
package rmac_pkg;

    localparam int FUNC_W    = 2;
    localparam int ADDR_W    = 32;
    localparam int WCODE_W   = 2;
    localparam int SLOT_W    = 3;
    localparam int LEN_W     = 33;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int HIT_W     = 3;
    localparam int WHITS_W   = 4;
    localparam int IDX_EXT_W = 6;

    localparam logic [FUNC_W-1:0] FN_READ        = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE       = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD_REGION = 2'd2;
    localparam logic [FUNC_W-1:0] FN_LOAD_WATCH  = 2'd3;

    localparam logic [WCODE_W-1:0] WC_BYTE = 2'd0;
    localparam logic [WCODE_W-1:0] WC_HALF = 2'd1;
    localparam logic [WCODE_W-1:0] WC_WORD = 2'd2;
    localparam logic [WCODE_W-1:0] WC_BAD  = 2'd3;

    localparam logic [MODE_W-1:0] WK_READ  = 2'd0;
    localparam logic [MODE_W-1:0] WK_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] WK_BOTH  = 2'd2;
    localparam logic [MODE_W-1:0] WK_BAD   = 2'd3;
    localparam logic [MODE_W-1:0] RM_RW    = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CROSS      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READONLY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BADSETUP   = 3'd6;

    // One past the top of the 32-bit address space.
    localparam logic [LEN_W-1:0] SPACE_END = {1'b1, 32'h0000_0000};

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RSCAN,
        S_WSCAN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic rstep;
        logic wstep;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_rscan;
        logic rscan_end;
        logic go_wscan;
        logic wscan_end;
    } dp_stat_t;

endpackage

FILE: design/rmac_ctrl.sv
module rmac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    input  rmac_pkg::dp_stat_t stat,
    output logic              in_ready,
    output logic              out_valid,
    output rmac_pkg::dp_cmd_t  cmd
);
    import rmac_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.need_rscan ? S_RSCAN : S_DONE;
            end
            S_RSCAN:
            begin
                cmd.rstep = 1'b1;
                if (stat.rscan_end)
                    state_next = stat.go_wscan ? S_WSCAN : S_DONE;
            end
            S_WSCAN:
            begin
                cmd.wstep = 1'b1;
                if (stat.wscan_end)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/rmac_dp.sv
module rmac_dp #(
    parameter int REGION_SLOTS = 8,
    parameter int WATCH_SLOTS  = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  rmac_pkg::dp_cmd_t                cmd,
    output rmac_pkg::dp_stat_t               stat,
    input  logic [rmac_pkg::FUNC_W-1:0]     func,
    input  logic [rmac_pkg::ADDR_W-1:0]     address,
    input  logic [rmac_pkg::WCODE_W-1:0]    width_code,
    input  logic [rmac_pkg::SLOT_W-1:0]     slot,
    input  logic [rmac_pkg::LEN_W-1:0]      length,
    input  logic [rmac_pkg::MODE_W-1:0]     access_mode,
    output logic [rmac_pkg::STATUS_W-1:0]   status,
    output logic [rmac_pkg::HIT_W-1:0]      region_hit,
    output logic [rmac_pkg::ADDR_W-1:0]     offset,
    output logic [rmac_pkg::WHITS_W-1:0]    watch_hits
);
    import rmac_pkg::*;

    localparam int RIDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int WIDX_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
    localparam int WSCAN  = (WATCH_SLOTS < WHITS_W) ? WATCH_SLOTS : WHITS_W;
    localparam int CNT_W  = (RIDX_W > WIDX_W) ? RIDX_W : WIDX_W;

    // item and working registers
    logic [FUNC_W-1:0]   func_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [WCODE_W-1:0]  wcode_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [LEN_W-1:0]    end_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [HIT_W-1:0]    hit_reg;
    logic [ADDR_W-1:0]   offs_reg;
    logic [WHITS_W-1:0]  wh_reg;
    logic                strict_reg;

    // result register
    logic [STATUS_W-1:0] status_reg;
    logic [HIT_W-1:0]    region_hit_reg;
    logic [ADDR_W-1:0]   offset_reg;
    logic [WHITS_W-1:0]  watch_hits_reg;

    // slot tables; ends are stored as base plus length
    logic [ADDR_W-1:0]       rg_start_reg [REGION_SLOTS];
    logic [LEN_W-1:0]        rg_end_reg   [REGION_SLOTS];
    logic [REGION_SLOTS-1:0] rg_wr_reg;
    logic [REGION_SLOTS-1:0] rg_valid_reg;
    logic [ADDR_W-1:0]       wp_start_reg [WATCH_SLOTS];
    logic [LEN_W-1:0]        wp_end_reg   [WATCH_SLOTS];
    logic [MODE_W-1:0]       wp_kind_reg  [WATCH_SLOTS];
    logic [WATCH_SLOTS-1:0]  wp_valid_reg;

    logic                 is_access;
    logic                 is_write;
    logic [LEN_W-1:0]     size;
    logic [LEN_W-1:0]     lo;
    logic [LEN_W-1:0]     acc_end;
    logic [LEN_W:0]       load_sum;
    logic                 misalign;
    logic                 acc_ovf;
    logic                 load_ovf;
    logic [IDX_EXT_W-1:0] slot_ext;
    logic [IDX_EXT_W-1:0] cnt_ext;
    logic [RIDX_W-1:0]    slot_r;
    logic [WIDX_W-1:0]    slot_w;
    logic [RIDX_W-1:0]    ridx;
    logic [WIDX_W-1:0]    widx;
    logic                 rload_bad;
    logic                 wload_bad;
    logic [STATUS_W-1:0]  check_status;
    logic [LEN_W-1:0]     r_start;
    logic [LEN_W-1:0]     r_end;
    logic                 r_hit;
    logic                 r_cross;
    logic                 r_ro;
    logic                 r_overlap;
    logic                 r_last;
    logic [MODE_W-1:0]    w_kind;
    logic                 w_kind_ok;
    logic                 w_hit;
    logic                 w_last;

    assign is_access = !func_reg[1];
    assign is_write  = (func_reg == FN_WRITE);
    assign lo        = {1'b0, addr_reg};

    always_comb
    begin
        case (wcode_reg)
            WC_BYTE: size = LEN_W'(1);
            WC_HALF: size = LEN_W'(2);
            WC_WORD: size = LEN_W'(4);
            default: size = '0;
        endcase
    end

    assign acc_end  = lo + size;
    assign load_sum = {2'b00, addr_reg} + {1'b0, len_reg};
    assign misalign = strict_reg &&
                      (((wcode_reg == WC_HALF) && addr_reg[0]) ||
                       ((wcode_reg == WC_WORD) && (addr_reg[1:0] != 2'b00)));
    assign acc_ovf  = (acc_end > SPACE_END);
    assign load_ovf = (load_sum > {1'b0, SPACE_END});

    assign slot_ext = IDX_EXT_W'(slot_reg);
    assign cnt_ext  = IDX_EXT_W'(cnt_reg);
    assign slot_r   = slot_ext[RIDX_W-1:0];
    assign slot_w   = slot_ext[WIDX_W-1:0];
    assign ridx     = cnt_ext[RIDX_W-1:0];
    assign widx     = cnt_ext[WIDX_W-1:0];

    assign rload_bad = (slot_ext >= IDX_EXT_W'(REGION_SLOTS)) || (mode_reg > RM_RW) ||
                       (len_reg == '0) || load_ovf;
    assign wload_bad = (slot_ext >= IDX_EXT_W'(WATCH_SLOTS)) ||
                       ((len_reg != '0) && ((mode_reg == WK_BAD) || load_ovf));

    always_comb
    begin
        case (func_reg)
            FN_READ, FN_WRITE:
            begin
                if (wcode_reg == WC_BAD)
                    check_status = ST_BADSETUP;
                else if (misalign)
                    check_status = ST_MISALIGNED;
                else if (acc_ovf)
                    check_status = ST_OVERFLOW;
                else
                    check_status = ST_OK;
            end
            FN_LOAD_REGION: check_status = rload_bad ? ST_BADSETUP : ST_OK;
            FN_LOAD_WATCH:  check_status = wload_bad ? ST_BADSETUP : ST_OK;
            default:        check_status = ST_BADSETUP;
        endcase
    end

    // one region slot per cycle
    assign r_start   = {1'b0, rg_start_reg[ridx]};
    assign r_end     = rg_end_reg[ridx];
    assign r_hit     = rg_valid_reg[ridx] && (lo >= r_start) && (lo < r_end);
    assign r_cross   = (end_reg > r_end);
    assign r_ro      = is_write && !rg_wr_reg[ridx];
    assign r_overlap = (cnt_ext != slot_ext) && rg_valid_reg[ridx] &&
                       (lo < r_end) && (r_start < end_reg);
    assign r_last    = (cnt_reg == CNT_W'(REGION_SLOTS - 1));

    // one watchpoint slot per cycle
    assign w_kind    = wp_kind_reg[widx];
    assign w_kind_ok = (w_kind == WK_BOTH) || ((w_kind == WK_READ) && !is_write) ||
                       ((w_kind == WK_WRITE) && is_write);
    assign w_hit     = wp_valid_reg[widx] && w_kind_ok &&
                       ({1'b0, wp_start_reg[widx]} < end_reg) && (lo < wp_end_reg[widx]);
    assign w_last    = (cnt_reg == CNT_W'(WSCAN - 1));

    assign stat.need_rscan = (check_status == ST_OK) && (func_reg != FN_LOAD_WATCH);
    assign stat.rscan_end  = r_last || (is_access && r_hit) || (!is_access && r_overlap);
    assign stat.go_wscan   = is_access && r_hit && !r_cross && !r_ro;
    assign stat.wscan_end  = w_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strict_reg <= 1'b1;
        else if (cfg_wr_en)
            strict_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            addr_reg  <= address;
            wcode_reg <= width_code;
            slot_reg  <= slot;
            len_reg   <= length;
            mode_reg  <= access_mode;
        end
        if (cmd.check)
        begin
            st_reg   <= check_status;
            hit_reg  <= '0;
            offs_reg <= '0;
            wh_reg   <= '0;
            end_reg  <= is_access ? acc_end : load_sum[LEN_W-1:0];
            cnt_reg  <= '0;
        end
        if (cmd.rstep)
        begin
            if (is_access)
            begin
                if (r_hit)
                begin
                    hit_reg <= cnt_ext[HIT_W-1:0];
                    if (r_cross)
                        st_reg <= ST_CROSS;
                    else if (r_ro)
                        st_reg <= ST_READONLY;
                    else
                        offs_reg <= addr_reg - r_start[ADDR_W-1:0];
                end
                else if (r_last)
                    st_reg <= ST_UNMAPPED;
            end
            else if (r_overlap)
                st_reg <= ST_BADSETUP;
            cnt_reg <= stat.rscan_end ? '0 : cnt_reg + CNT_W'(1);
        end
        if (cmd.wstep)
        begin
            if (w_hit)
                wh_reg[cnt_ext[1:0]] <= 1'b1;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            status_reg     <= st_reg;
            region_hit_reg <= hit_reg;
            offset_reg     <= offs_reg;
            watch_hits_reg <= wh_reg;
        end
    end

    // table contents
    always_ff @(posedge clk)
    begin
        if (cmd.finish && (st_reg == ST_OK))
        begin
            if (func_reg == FN_LOAD_REGION)
            begin
                rg_start_reg[slot_r] <= addr_reg;
                rg_end_reg[slot_r]   <= end_reg;
                rg_wr_reg[slot_r]    <= mode_reg[0];
            end
            if ((func_reg == FN_LOAD_WATCH) && (len_reg != '0))
            begin
                wp_start_reg[slot_w] <= addr_reg;
                wp_end_reg[slot_w]   <= end_reg;
                wp_kind_reg[slot_w]  <= mode_reg;
            end
        end
    end

    // slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rg_valid_reg <= '0;
            wp_valid_reg <= '0;
        end
        else if (cmd.finish && (st_reg == ST_OK))
        begin
            if (func_reg == FN_LOAD_REGION)
                rg_valid_reg[slot_r] <= 1'b1;
            if (func_reg == FN_LOAD_WATCH)
                wp_valid_reg[slot_w] <= (len_reg != '0);
        end
    end

    assign status     = status_reg;
    assign region_hit = region_hit_reg;
    assign offset     = offset_reg;
    assign watch_hits = watch_hits_reg;

endmodule

FILE: design/region_map_access_checker_core.sv
// Channel   Handshake                   Payload
// -------   -------------------------   ----------------------------------------------
// in        in_valid / in_ready         func, address, width_code, slot, length,
//                                       access_mode
// out       out_valid / out_ready       status, region_hit, offset, watch_hits
// cfg       cfg_wr_en (no wait)         cfg_wr_data -> strict_alignment
//
// One transaction at a time. After acceptance: a decode step, then a walk of the
// region table one slot per cycle (stops at the hit), then for a clean access a walk
// of up to min(WATCH_SLOTS, 4) watchpoint slots, then a final step to load the output
// register.
// rst_n clears the state machine, the output valid, all slot valid bits and sets
// strict alignment. A stalled output holds its result; the next input transaction is
// still taken and only waits at its own final step while the output register is full.
module region_map_access_checker_core #(
    parameter int REGION_SLOTS = 8,
    parameter int WATCH_SLOTS  = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    // input transaction
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rmac_pkg::FUNC_W-1:0]     func,
    input  logic [rmac_pkg::ADDR_W-1:0]     address,
    input  logic [rmac_pkg::WCODE_W-1:0]    width_code,
    input  logic [rmac_pkg::SLOT_W-1:0]     slot,
    input  logic [rmac_pkg::LEN_W-1:0]      length,
    input  logic [rmac_pkg::MODE_W-1:0]     access_mode,
    // result transaction
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rmac_pkg::STATUS_W-1:0]   status,
    output logic [rmac_pkg::HIT_W-1:0]      region_hit,
    output logic [rmac_pkg::ADDR_W-1:0]     offset,
    output logic [rmac_pkg::WHITS_W-1:0]    watch_hits
);
    import rmac_pkg::*;

    // Commands from the sequencer tell the datapath to capture the transaction,
    // decode it, advance one table slot or publish the result; status flags
    // come back to steer the sequencer.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    rmac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Slot tables, transaction registers, the slot comparators and the result
    // register all live in the datapath.
    rmac_dp #(
        .REGION_SLOTS (REGION_SLOTS),
        .WATCH_SLOTS  (WATCH_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .address     (address),
        .width_code  (width_code),
        .slot        (slot),
        .length      (length),
        .access_mode (access_mode),
        .status      (status),
        .region_hit  (region_hit),
        .offset      (offset),
        .watch_hits  (watch_hits)
    );

endmodule

FILE: design/rmac_checker.sv
`include "region_map_access_checker_core_defines.svh"

module rmac_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rmac_pkg::STATUS_W-1:0] status,
    input logic [rmac_pkg::HIT_W-1:0]    region_hit,
    input logic [rmac_pkg::ADDR_W-1:0]   offset,
    input logic [rmac_pkg::WHITS_W-1:0]  watch_hits
);
    import rmac_pkg::*;

    // a stalled result holds
    `RMAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(offset))

    // one transaction in flight: no acceptance right after another
    `RMAC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // only a clean access reports an offset or watchpoints
    `RMAC_ASSERT_NOW(a_fail_no_payload, out_valid && (status != ST_OK), (offset == '0) && (watch_hits == '0))

    // failures with no region hit (unmapped, misaligned, overflow, bad setup) carry no region
    `RMAC_ASSERT_NOW(a_no_region, out_valid && ((status == ST_UNMAPPED) || (status == ST_MISALIGNED) || (status == ST_OVERFLOW) || (status == ST_BADSETUP)), region_hit == '0)

endmodule

bind region_map_access_checker_core rmac_checker u_rmac_checker (.*);

FILE: test/region_map_tb_pkg.sv
`timescale 1ns / 100ps

package region_map_tb_pkg;

    import rmac_pkg::*;

    localparam int NUM_REGIONS = 8;
    localparam int NUM_WATCH   = 4;

    // Region mode codes beside the read-write one in the package.
    localparam logic [MODE_W-1:0] RM_RO   = 2'd0;
    localparam logic [MODE_W-1:0] RM_OVER = 2'd2;

    // Wide enough that base + length never wraps.
    typedef logic [LEN_W:0] span_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  address;
        logic [WCODE_W-1:0] width_code;
        logic [SLOT_W-1:0]  slot;
        logic [LEN_W-1:0]   length;
        logic [MODE_W-1:0]  access_mode;
    } access_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HIT_W-1:0]    region_hit;
        logic [ADDR_W-1:0]   offset;
        logic [WHITS_W-1:0]  watch_hits;
    } access_resp_t;

    class verdict_scoreboard;

        bit                 strict_align;
        logic [ADDR_W-1:0]  rg_base [NUM_REGIONS];
        logic [LEN_W-1:0]   rg_len  [NUM_REGIONS];
        bit                 rg_wr   [NUM_REGIONS];
        bit                 rg_on   [NUM_REGIONS];
        logic [ADDR_W-1:0]  wp_base [NUM_WATCH];
        logic [LEN_W-1:0]   wp_len  [NUM_WATCH];
        logic [MODE_W-1:0]  wp_kind [NUM_WATCH];
        bit                 wp_on   [NUM_WATCH];

        access_resp_t expected_verdicts[$];
        int           errors;
        int           seen;

        function new();
            strict_align = 1'b1;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                rg_base[i] = '0;
                rg_len[i]  = '0;
                rg_wr[i]   = 1'b0;
                rg_on[i]   = 1'b0;
            end
            for (int i = 0; i < NUM_WATCH; i++)
            begin
                wp_base[i] = '0;
                wp_len[i]  = '0;
                wp_kind[i] = '0;
                wp_on[i]   = 1'b0;
            end
            errors = 0;
            seen   = 0;
        endfunction

        task flag_error(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        function bit spans_meet(span_t a_lo, span_t a_len, span_t b_lo, span_t b_len);
            return (a_lo < b_lo + b_len) && (b_lo < a_lo + a_len);
        endfunction

        function logic [STATUS_W-1:0] load_region(access_req_t r);
            if (r.access_mode > RM_RW || r.length == '0)
                return ST_BADSETUP;
            if (span_t'(r.address) + span_t'(r.length) > span_t'(SPACE_END))
                return ST_BADSETUP;
            // the slot being replaced does not count against itself
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                if (i != int'(r.slot) && rg_on[i] &&
                    spans_meet(span_t'(r.address), span_t'(r.length),
                               span_t'(rg_base[i]), span_t'(rg_len[i])))
                    return ST_BADSETUP;
            end
            rg_base[r.slot] = r.address;
            rg_len[r.slot]  = r.length;
            rg_wr[r.slot]   = r.access_mode[0];
            rg_on[r.slot]   = 1'b1;
            return ST_OK;
        endfunction

        function logic [STATUS_W-1:0] load_watch(access_req_t r);
            if (int'(r.slot) >= NUM_WATCH)
                return ST_BADSETUP;
            if (r.length == '0)
            begin
                wp_base[r.slot[1:0]] = '0;
                wp_len[r.slot[1:0]]  = '0;
                wp_kind[r.slot[1:0]] = '0;
                wp_on[r.slot[1:0]]   = 1'b0;
                return ST_OK;
            end
            if (r.access_mode > WK_BOTH ||
                span_t'(r.address) + span_t'(r.length) > span_t'(SPACE_END))
                return ST_BADSETUP;
            wp_base[r.slot[1:0]] = r.address;
            wp_len[r.slot[1:0]]  = r.length;
            wp_kind[r.slot[1:0]] = r.access_mode;
            wp_on[r.slot[1:0]]   = 1'b1;
            return ST_OK;
        endfunction

        function access_resp_t apply_request(access_req_t r);
            access_resp_t      v;
            span_t             size;
            span_t             lo;
            span_t             hi;
            span_t             rlo;
            span_t             rhi;
            logic [ADDR_W-1:0] align_mask;
            logic [MODE_W-1:0] k;
            bit                is_wr;
            bit                found;
            bit                kind_ok;
            v = '0;
            if (r.func == FN_LOAD_REGION)
                v.status = load_region(r);
            else if (r.func == FN_LOAD_WATCH)
                v.status = load_watch(r);
            else if (r.width_code == WC_BAD)
                v.status = ST_BADSETUP;
            else
            begin
                size       = span_t'(1) << r.width_code;
                lo         = span_t'(r.address);
                hi         = lo + size;
                align_mask = size[ADDR_W-1:0] - 1'b1;
                is_wr      = (r.func == FN_WRITE);
                found      = 1'b0;
                if (strict_align && (r.address & align_mask) != '0)
                    v.status = ST_MISALIGNED;
                else if (hi > span_t'(SPACE_END))
                    v.status = ST_OVERFLOW;
                else
                begin
                    for (int i = 0; i < NUM_REGIONS; i++)
                    begin
                        rlo = span_t'(rg_base[i]);
                        rhi = rlo + span_t'(rg_len[i]);
                        if (!found && rg_on[i] && lo >= rlo && lo < rhi)
                        begin
                            found        = 1'b1;
                            v.region_hit = i[HIT_W-1:0];
                            if (hi > rhi)
                                v.status = ST_CROSS;
                            else if (is_wr && !rg_wr[i])
                                v.status = ST_READONLY;
                            else
                                v.offset = r.address - rg_base[i];
                        end
                    end
                    if (!found)
                        v.status = ST_UNMAPPED;
                end
                if (v.status == ST_OK)
                begin
                    for (int i = 0; i < NUM_WATCH; i++)
                    begin
                        k       = wp_kind[i];
                        kind_ok = (k == WK_BOTH) || (k == WK_READ && !is_wr) ||
                                  (k == WK_WRITE && is_wr);
                        if (wp_on[i] && kind_ok &&
                            spans_meet(span_t'(wp_base[i]), span_t'(wp_len[i]), lo, size))
                            v.watch_hits[i] = 1'b1;
                    end
                end
            end
            return v;
        endfunction

        function void note_request(access_req_t r);
            expected_verdicts.insert(expected_verdicts.size(), apply_request(r));
        endfunction

        task check_response(access_resp_t got);
            access_resp_t want;
            if (expected_verdicts.size() == 0)
            begin
                flag_error($sformatf("result with nothing pending: status %0d hit %0d off %h",
                                     got.status, got.region_hit, got.offset));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (got !== want)
                    flag_error($sformatf(
                        "result %0d: got st %0d hit %0d off %h wh %b, want st %0d hit %0d off %h wh %b",
                        seen, got.status, got.region_hit, got.offset, got.watch_hits,
                        want.status, want.region_hit, want.offset, want.watch_hits));
            end
            seen++;
        endtask

    endclass

endpackage

FILE: test/tb_region_map_access_checker_core.sv
`timescale 1ns / 100ps

module tb_region_map_access_checker_core;

    import rmac_pkg::*;
    import region_map_tb_pkg::*;

    // Run limit for the watchdog; it sits above the slowest transactions in the block, the
    // longest sender gap (MAX_GAP) and long receiver stalls.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 850;
    localparam int NUM_PHASES   = 8;
    localparam int MAX_GAP      = 40;
    localparam int SETTLE       = 20;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func        = '0;
    logic [ADDR_W-1:0]   address     = '0;
    logic [WCODE_W-1:0]  width_code  = '0;
    logic [SLOT_W-1:0]   slot        = '0;
    logic [LEN_W-1:0]    length      = '0;
    logic [MODE_W-1:0]   access_mode = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [HIT_W-1:0]    region_hit;
    logic [ADDR_W-1:0]   offset;
    logic [WHITS_W-1:0]  watch_hits;

    verdict_scoreboard sb = new();

    // Percent of cycles in which the sender idles / the receiver stalls.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    region_map_access_checker_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .address     (address),
        .width_code  (width_code),
        .slot        (slot),
        .length      (length),
        .access_mode (access_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .region_hit  (region_hit),
        .offset      (offset),
        .watch_hits  (watch_hits)
    );

    // 8 ns period, starting low so the first edge seen is a rising one at 4 ns.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: drop ready at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: sample both handshakes at the edge, before this edge's updates land.
    // Predict each accepted request in order; check each accepted result.
    always @(posedge clk)
    begin : monitor
        access_req_t  seen_req;
        access_resp_t seen_resp;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen_req.func        = func;
                seen_req.address     = address;
                seen_req.width_code  = width_code;
                seen_req.slot        = slot;
                seen_req.length      = length;
                seen_req.access_mode = access_mode;
                sb.note_request(seen_req);
            end
            if (out_valid && out_ready)
            begin
                seen_resp.status     = status;
                seen_resp.region_hit = region_hit;
                seen_resp.offset     = offset;
                seen_resp.watch_hits = watch_hits;
                sb.check_response(seen_resp);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin : watchdog
        int n;
        n = 0;
        while (n < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic access_req_t mk(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                       logic [WCODE_W-1:0] w, logic [SLOT_W-1:0] s,
                                       logic [LEN_W-1:0] l, logic [MODE_W-1:0] m);
        access_req_t r;
        r.func        = f;
        r.address     = a;
        r.width_code  = w;
        r.slot        = s;
        r.length      = l;
        r.access_mode = m;
        return r;
    endfunction

    // Append one request to a list of directed requests.
    task automatic add_req(ref access_req_t q[$], input access_req_t r);
        q.insert(q.size(), r);
    endtask

    // Random request. Most accesses aim at loaded regions and watchpoints so that they
    // get past the unmapped check; the rest are noise, top-of-space and misaligned cases.
    // Unused fields carry random noise on every transaction.
    function automatic access_req_t pick_request();
        access_req_t       r;
        int                live[$];
        int                k;
        int                choice;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] sz;
        r.func        = FUNC_W'($urandom_range(0, 3));
        r.address     = $urandom();
        r.width_code  = ($urandom_range(0, 99) < 4) ? WC_BAD : WCODE_W'($urandom_range(0, 2));
        r.slot        = SLOT_W'($urandom_range(0, 7));
        r.length      = {1'($urandom_range(0, 1)), $urandom()};
        r.access_mode = MODE_W'($urandom_range(0, 3));
        for (int i = 0; i < NUM_REGIONS; i++)
            if (sb.rg_on[i])
                live.insert(live.size(), i);
        choice = $urandom_range(0, 99);
        if (choice < 14)
        begin
            // region load, on a coarse grid so that neighbors sometimes collide
            r.func        = FN_LOAD_REGION;
            r.access_mode = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(2, 3))
                                                        : MODE_W'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    r.address = ($urandom_range(0, 7) << 28) | ($urandom_range(0, 63) << 6);
                    r.length  = LEN_W'($urandom_range(1, 96));
                end
                6:
                    r.length = '0;
                7:
                begin
                    r.address = 32'hFFFF_FFFF - $urandom_range(0, 255);
                    r.length  = LEN_W'($urandom_range(1, 512));
                end
                8:
                begin
                    r.address = ($urandom_range(0, 1) == 0) ? '0 : $urandom();
                    r.length  = ($urandom_range(0, 3) == 0) ? SPACE_END : {1'b0, $urandom()};
                end
                default:
                begin
                    // land right on or just inside the end of a live region
                    if (live.size() != 0)
                    begin
                        k         = live[$urandom_range(0, live.size() - 1)];
                        r.address = sb.rg_base[k] + sb.rg_len[k][ADDR_W-1:0]
                                    - $urandom_range(0, 2);
                    end
                    r.length = LEN_W'($urandom_range(1, 32));
                end
            endcase
        end
        else if (choice < 24)
        begin
            r.func = FN_LOAD_WATCH;
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                    r.length = '0;
                4, 5, 6:
                begin
                    r.address = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                    r.length  = LEN_W'($urandom_range(1, 32));
                end
                7, 8, 9:
                begin
                    r.address = $urandom();
                    r.length  = ($urandom_range(0, 1) == 0) ? SPACE_END : {1'b0, $urandom()};
                end
                default:
                begin
                    if (live.size() != 0)
                    begin
                        k         = live[$urandom_range(0, live.size() - 1)];
                        r.address = sb.rg_base[k] + $urandom_range(0, 64);
                    end
                    r.length = LEN_W'($urandom_range(1, 16));
                end
            endcase
        end
        else
        begin
            r.func = ($urandom_range(0, 1) == 0) ? FN_READ : FN_WRITE;
            choice = $urandom_range(0, 99);
            if (choice < 60 && live.size() != 0)
            begin
                k    = live[$urandom_range(0, live.size() - 1)];
                base = sb.rg_base[k];
                len  = sb.rg_len[k];
                case ($urandom_range(0, 3))
                    0, 1:
                        r.address = (len[LEN_W-1]) ? $urandom() : base + $urandom() % len[31:0];
                    2:
                        r.address = base + len[ADDR_W-1:0] - $urandom_range(1, 4);
                    default:
                        r.address = base - $urandom_range(1, 3);
                endcase
            end
            else if (choice < 75)
            begin
                k         = $urandom_range(0, NUM_WATCH - 1);
                r.address = sb.wp_base[k] + $urandom_range(0, 8) - 4;
            end
            else if (choice < 85)
                r.address = 32'hFFFF_FFFF - $urandom_range(0, 7);
            else
                r.address = $urandom();
            // under strict alignment, align most accesses so they go deeper
            sz = 32'd1 << r.width_code;
            if (sb.strict_align && $urandom_range(0, 9) < 7)
                r.address = r.address & ~(sz - 1'b1);
        end
        return r;
    endfunction

    // Present one request and hold it until accepted. Returns at the accepting edge
    // with valid still high; the next call either keeps it up or drops it once.
    task automatic send_request(input access_req_t r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= r.func;
        address     <= r.address;
        width_code  <= r.width_code;
        slot        <= r.slot;
        length      <= r.length;
        access_mode <= r.access_mode;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every pending result has come back. The first edge
    // lets the monitor record the transaction accepted at the current one.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the alignment mode; only called with the block idle.
    task automatic set_strict(input bit v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        sb.strict_align = v;
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        access_req_t directed[$];
        access_req_t late[$];
        int          per_phase;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, strict alignment from reset.
        add_req(directed, mk(FN_READ,        32'h0000_0000, WC_BYTE, 3'd0, 33'h0,   RM_RO));
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_1000, WC_BYTE, 3'd0, 33'h100, RM_RW));
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_2000, WC_BYTE, 3'd1, 33'h10,  RM_RO));
        // overlap with a live slot is refused
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_1080, WC_BYTE, 3'd2, 33'h10,  RM_RW));
        // reload may overlap its own old contents
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_1010, WC_BYTE, 3'd0, 33'h100, RM_RW));
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_4000, WC_BYTE, 3'd3, 33'h0,   RM_RW));
        add_req(directed, mk(FN_LOAD_REGION, 32'hFFFF_FF00, WC_BYTE, 3'd3, 33'h101, RM_RW));
        add_req(directed, mk(FN_LOAD_REGION, 32'hFFFF_FF00, WC_BYTE, 3'd7, 33'h100, RM_RW));
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_5000, WC_BYTE, 3'd4, 33'h10,  RM_OVER));
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_0000, WC_BYTE, 3'd5, SPACE_END, RM_RO));
        add_req(directed, mk(FN_LOAD_REGION, 32'h0000_3000, WC_BYTE, 3'd3, 33'h3,   RM_RW));
        add_req(directed, mk(FN_LOAD_WATCH,  32'h0000_1010, WC_BYTE, 3'd0, 33'h4,   WK_READ));
        add_req(directed, mk(FN_LOAD_WATCH,  32'h0000_2000, WC_BYTE, 3'd1, 33'h8,   WK_WRITE));
        add_req(directed, mk(FN_LOAD_WATCH,  32'h0000_1010, WC_BYTE, 3'd2, 33'h100, WK_BOTH));
        add_req(directed, mk(FN_LOAD_WATCH,  32'h0000_1010, WC_BYTE, 3'd3, 33'h4,   WK_BAD));
        add_req(directed, mk(FN_LOAD_WATCH,  32'h0000_1010, WC_BYTE, 3'd5, 33'h4,   WK_BOTH));
        add_req(directed, mk(FN_LOAD_WATCH,  32'hFFFF_FFFF, WC_BYTE, 3'd3, 33'h2,   WK_BOTH));
        add_req(directed, mk(FN_LOAD_WATCH,  32'h0000_0000, WC_BYTE, 3'd3, SPACE_END, WK_BOTH));
        // zero length clears the slot whatever the mode
        add_req(directed, mk(FN_LOAD_WATCH,  32'h0000_ABCD, WC_BYTE, 3'd3, 33'h0,   WK_BAD));
        add_req(directed, mk(FN_READ,        32'h0000_1010, WC_WORD, 3'd0, 33'h0,   RM_RO));
        add_req(directed, mk(FN_WRITE,       32'h0000_2006, WC_HALF, 3'd0, 33'h0,   RM_RO));
        add_req(directed, mk(FN_READ,        32'h0000_1011, WC_WORD, 3'd0, 33'h0,   RM_RO));
        add_req(directed, mk(FN_READ,        32'h0000_3000, WC_WORD, 3'd0, 33'h0,   RM_RO));
        add_req(directed, mk(FN_READ,        32'hFFFF_FFFC, WC_WORD, 3'd0, 33'h0,   RM_RO));
        add_req(directed, mk(FN_WRITE,       32'h0000_1000, WC_BAD,  3'd0, 33'h0,   RM_RO));
        // with alignment relaxed: overflow, an unmapped access just below a region, unaligned hit
        add_req(late, mk(FN_READ,  32'hFFFF_FFFE, WC_WORD, 3'd0, 33'h0, RM_RO));
        add_req(late, mk(FN_READ,  32'h0000_0FFE, WC_WORD, 3'd0, 33'h0, RM_RO));
        add_req(late, mk(FN_WRITE, 32'h0000_1012, WC_WORD, 3'd0, 33'h0, RM_RO));

        foreach (directed[i])
            send_request(directed[i]);
        drain_results();
        set_strict(1'b0);
        foreach (late[i])
            send_request(late[i]);
        drain_results();

        // Random part: every idling mode under both alignment settings.
        per_phase = RANDOM_ITEMS / NUM_PHASES;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 75;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 75;
                end
                default:
                begin
                    sender_idle_pct = 37;
                    recv_stall_pct  = 37;
                end
            endcase
            set_strict(p % 2 == 0);
            repeat (per_phase)
                send_request(pick_request());
            drain_results();
        end

        // Let any stray result show up before the verdict.
        repeat (SETTLE) @(posedge clk);
        if (sb.expected_verdicts.size() != 0)
            sb.flag_error($sformatf("%0d results never arrived", sb.expected_verdicts.size()));
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
